FILE: hdl/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants and controller/datapath interface types for the indexed
// sequential search store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned PAGE_ITEMS  = 64;
  localparam int unsigned MAX_PAGES   = 256;
  localparam int unsigned STORE_SLOTS = PAGE_ITEMS * MAX_PAGES;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FIRST_W  = 32;
  localparam int unsigned SECOND_W = 64;
  localparam int unsigned REC_W    = KEY_W + FIRST_W + SECOND_W;
  localparam int unsigned ACT_W    = 2;

  localparam int unsigned SLOT_W  = $clog2(STORE_SLOTS);
  localparam int unsigned CNT_W   = $clog2(STORE_SLOTS + 1);
  localparam int unsigned ITEM_W  = $clog2(PAGE_ITEMS);
  localparam int unsigned QTY_W   = $clog2(PAGE_ITEMS + 1);
  localparam int unsigned PAGE_W  = $clog2(MAX_PAGES);
  localparam int unsigned PGCNT_W = $clog2(MAX_PAGES + 1);

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic start;
    logic idx_run;
    logic rec_init;
    logic rec_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic p_zero;
    logic rec_end;
  } status_t;

endpackage

FILE: hdl/iss_dp.sv
// ----------------------------------------------------------------------------
// iss_dp
// Datapath: record and page index memories, record count, pipelined index
// and page scans, and the result register.
// ----------------------------------------------------------------------------
module iss_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  iss_pkg::cmd_t                        cmd_i,
  output iss_pkg::status_t                     status_o,
  input  logic signed [iss_pkg::KEY_W-1:0]     key_i,
  input  logic signed [iss_pkg::FIRST_W-1:0]   first_data_i,
  input  logic        [iss_pkg::SECOND_W-1:0]  second_data_i,
  output logic                                 found_o,
  output logic signed [iss_pkg::KEY_W-1:0]     found_key_o,
  output logic signed [iss_pkg::FIRST_W-1:0]   found_first_o,
  output logic        [iss_pkg::SECOND_W-1:0]  found_second_o
);

  logic [iss_pkg::REC_W-1:0] rec_mem [iss_pkg::STORE_SLOTS];
  logic [iss_pkg::KEY_W-1:0] idx_mem [iss_pkg::MAX_PAGES];

  logic [iss_pkg::CNT_W-1:0]   count_q, count_d;
  logic [iss_pkg::PGCNT_W-1:0] ip_q, ip_d;
  logic                        irv_q, irv_d;
  logic [iss_pkg::PGCNT_W-1:0] iri_q;
  logic [iss_pkg::PGCNT_W-1:0] p_q, p_d;
  logic [iss_pkg::QTY_W-1:0]   rp_q, rp_d;
  logic                        rrv_q, rrv_d;
  logic                        hit_q, hit_d;

  logic signed [iss_pkg::KEY_W-1:0] key_q;
  logic signed [iss_pkg::KEY_W-1:0] idx_rd_q;
  logic [iss_pkg::REC_W-1:0]        rec_rd_q;
  logic [iss_pkg::REC_W-1:0]        hit_rec_q;
  logic [iss_pkg::PAGE_W-1:0]       page_q;
  logic [iss_pkg::QTY_W-1:0]        qty_q;

  logic                        full;
  logic                        load_wr;
  logic [iss_pkg::CNT_W:0]     pg_sum;
  logic [iss_pkg::PGCNT_W-1:0] pages;
  logic                        idx_issue;
  logic                        idx_pass;
  logic                        rec_issue;
  logic                        rec_match;
  logic [iss_pkg::PAGE_W-1:0]  base_page;
  logic [iss_pkg::CNT_W-1:0]   base_slot;
  logic [iss_pkg::CNT_W-1:0]   last_fill;
  logic [iss_pkg::QTY_W-1:0]   qty_new;

  assign full    = (count_q == iss_pkg::CNT_W'(iss_pkg::STORE_SLOTS));
  assign load_wr = cmd_i.load && !full;

  assign pg_sum = {1'b0, count_q} + (iss_pkg::CNT_W + 1)'(iss_pkg::PAGE_ITEMS - 1);
  assign pages  = iss_pkg::PGCNT_W'(pg_sum >> iss_pkg::ITEM_W);

  assign idx_issue = cmd_i.idx_run && (ip_q < pages);
  assign idx_pass  = (idx_rd_q <= key_q);

  assign rec_match = rrv_q && (rec_rd_q[iss_pkg::REC_W-1 -: iss_pkg::KEY_W] == key_q);
  assign rec_issue = cmd_i.rec_run && (rp_q < qty_q);

  assign base_page = iss_pkg::PAGE_W'(p_q - iss_pkg::PGCNT_W'(1));
  assign base_slot = iss_pkg::CNT_W'({base_page, {iss_pkg::ITEM_W{1'b0}}});
  assign last_fill = count_q - base_slot;
  assign qty_new   = (p_q < pages) ? iss_pkg::QTY_W'(iss_pkg::PAGE_ITEMS)
                                   : iss_pkg::QTY_W'(last_fill);

  assign status_o.idx_end = (irv_q && !idx_pass) || (!irv_q && (ip_q >= pages));
  assign status_o.p_zero  = (p_q == '0);
  assign status_o.rec_end = rec_match || (!rrv_q && (rp_q >= qty_q));

  always_comb begin
    count_d = count_q;
    ip_d    = ip_q;
    irv_d   = irv_q;
    p_d     = p_q;
    rp_d    = rp_q;
    rrv_d   = rrv_q;
    hit_d   = hit_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (load_wr) begin
      count_d = count_q + iss_pkg::CNT_W'(1);
    end
    if (cmd_i.start) begin
      ip_d  = '0;
      irv_d = 1'b0;
      p_d   = '0;
      hit_d = 1'b0;
    end else if (cmd_i.idx_run) begin
      irv_d = idx_issue;
      if (idx_issue) begin
        ip_d = ip_q + iss_pkg::PGCNT_W'(1);
      end
      if (irv_q && idx_pass) begin
        p_d = iri_q + iss_pkg::PGCNT_W'(1);
      end
    end
    if (cmd_i.rec_init) begin
      rp_d  = '0;
      rrv_d = 1'b0;
    end else if (cmd_i.rec_run) begin
      rrv_d = rec_issue;
      if (rec_issue) begin
        rp_d = rp_q + iss_pkg::QTY_W'(1);
      end
      if (rec_match) begin
        hit_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ip_q    <= '0;
      irv_q   <= 1'b0;
      p_q     <= '0;
      rp_q    <= '0;
      rrv_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ip_q    <= ip_d;
      irv_q   <= irv_d;
      p_q     <= p_d;
      rp_q    <= rp_d;
      rrv_q   <= rrv_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q <= key_i;
    end
    if (idx_issue) begin
      iri_q <= ip_q;
    end
    if (cmd_i.rec_init) begin
      page_q <= base_page;
      qty_q  <= qty_new;
    end
    if (cmd_i.rec_run && rec_match) begin
      hit_rec_q <= rec_rd_q;
    end
    if (cmd_i.out_load) begin
      found_o <= hit_q;
      if (hit_q) begin
        found_key_o    <= hit_rec_q[iss_pkg::REC_W-1 -: iss_pkg::KEY_W];
        found_first_o  <= hit_rec_q[iss_pkg::SECOND_W +: iss_pkg::FIRST_W];
        found_second_o <= hit_rec_q[iss_pkg::SECOND_W-1:0];
      end else begin
        found_key_o    <= '0;
        found_first_o  <= '0;
        found_second_o <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      rec_mem[count_q[iss_pkg::SLOT_W-1:0]] <= {key_i, first_data_i, second_data_i};
    end
    if (rec_issue) begin
      rec_rd_q <= rec_mem[{page_q, rp_q[iss_pkg::ITEM_W-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr && (count_q[iss_pkg::ITEM_W-1:0] == '0)) begin
      idx_mem[count_q[iss_pkg::SLOT_W-1:iss_pkg::ITEM_W]] <= key_i;
    end
    if (idx_issue) begin
      idx_rd_q <= idx_mem[ip_q[iss_pkg::PAGE_W-1:0]];
    end
  end

endmodule

FILE: hdl/iss_ctrl.sv
// ----------------------------------------------------------------------------
// iss_ctrl
// Controller: accepts transactions, sequences the index scan and the page
// scan of a lookup, and owns the output valid flag.
// ----------------------------------------------------------------------------
module iss_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [iss_pkg::ACT_W-1:0] action_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  input  iss_pkg::status_t          status_i,
  output iss_pkg::cmd_t             cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_IDX  = 2'd1;
  localparam logic [1:0] ST_REC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_i)
            iss_pkg::ACT_LOAD: begin
              cmd_o.load = 1'b1;
            end
            iss_pkg::ACT_LOOKUP: begin
              cmd_o.start = 1'b1;
              state_d     = ST_IDX;
            end
            iss_pkg::ACT_CLEAR: begin
              cmd_o.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_IDX: begin
        cmd_o.idx_run = 1'b1;
        if (status_i.idx_end) begin
          if (status_i.p_zero) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.rec_init = 1'b1;
            state_d        = ST_REC;
          end
        end
      end
      ST_REC: begin
        cmd_o.rec_run = 1'b1;
        if (status_i.rec_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/indexed_sequential_search.sv
// ----------------------------------------------------------------------------
// indexed_sequential_search
// Paged record store with a page index; a lookup finds the page through the
// index and then scans that page for the first record with an equal key.
// ----------------------------------------------------------------------------
// Load, clear and unused actions leave the controller idle and are accepted
// one per cycle while no lookup holds the input. A lookup holds the input
// while it scans up to the filled pages of the index (at most 256), then up
// to the found page's fill (at most 64); both read one memory word per cycle.
// Reset empties the store at once; memory contents are not cleared.
module indexed_sequential_search (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [iss_pkg::ACT_W-1:0]     action_i,
  input  logic signed [iss_pkg::KEY_W-1:0]     key_i,
  input  logic signed [iss_pkg::FIRST_W-1:0]   first_data_i,
  input  logic        [iss_pkg::SECOND_W-1:0]  second_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 found_o,
  output logic signed [iss_pkg::KEY_W-1:0]     found_key_o,
  output logic signed [iss_pkg::FIRST_W-1:0]   found_first_o,
  output logic        [iss_pkg::SECOND_W-1:0]  found_second_o
);

  iss_pkg::cmd_t    cmd;
  iss_pkg::status_t status;

  iss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  iss_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .key_i          (key_i),
    .first_data_i   (first_data_i),
    .second_data_i  (second_data_i),
    .found_o        (found_o),
    .found_key_o    (found_key_o),
    .found_first_o  (found_first_o),
    .found_second_o (found_second_o)
  );

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !(out_valid_o && out_stall_i))
    else $error("Lookup result overwrote a pending transaction.");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (found_key_o == '0 && found_first_o == '0 && found_second_o == '0))
    else $error("Missed lookup returned nonzero fields.");

  a_scan_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.idx_run || cmd.rec_run) |-> in_stall_o)
    else $error("Input accepted while a lookup scan is running.");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("Loaded result did not become valid.");

endmodule
